FILE: hw/rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Shared widths and action codes of the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int ACT_W  = 4;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 7;

    localparam logic [ACT_W-1:0] ACT_SET       = 4'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE    = 4'd1;
    localparam logic [ACT_W-1:0] ACT_RETRIEVE  = 4'd2;
    localparam logic [ACT_W-1:0] ACT_LOCATE    = 4'd3;
    localparam logic [ACT_W-1:0] ACT_PUSH_F    = 4'd4;
    localparam logic [ACT_W-1:0] ACT_PUSH_B    = 4'd5;
    localparam logic [ACT_W-1:0] ACT_POP_F     = 4'd6;
    localparam logic [ACT_W-1:0] ACT_POP_B     = 4'd7;
    localparam logic [ACT_W-1:0] ACT_REM_ALL   = 4'd8;
    localparam logic [ACT_W-1:0] ACT_REVERSE   = 4'd9;

    typedef logic signed [DATA_W-1:0] t_word;

endpackage

FILE: hw/rtl/ils_ram.sv
// ----------------------------------------------------------------------------
// ils_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store
// List of up to DEPTH signed words with a live count, held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive i_action, i_position and i_item_value with
//   start; the request transfers on a clock edge where start is high
//   and busy is low. One request is in flight at a time.
//   Result channel: o_done pulses for one cycle with o_read_value, o_ok and
//   o_live_count. Every request yields exactly one result. The receiver
//   cannot stall; busy is already low in the cycle o_done is shown.
// Sequencing (transfer edge to result edge):
//   set inside the list, push back, pop back, misses: done from IDLE.
//   retrieve, remove/pop front, locate, push front, remove all equal:
//   stream through S_STREAM, one RAM read per entry walked; remove and
//   pop front shift the tail down, push front shifts the list up.
//   set past the end: S_ZERO writes one zero per gap entry, then the value.
//   reverse: S_REV reads both entries of each swapped pair, then writes both.
//   The single RAM port pair (one read, one write per cycle) sets this
//   sequencing.
// Reset: synchronous; the list becomes empty at once, no clearing pass.
// ----------------------------------------------------------------------------
module indexed_list_store #(
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [ils_pkg::ACT_W-1:0]  i_action,
    input  logic [ils_pkg::POS_W-1:0]  i_position,
    input  logic signed [31:0]         i_item_value,
    output logic                       o_done,
    output logic signed [31:0]         o_read_value,
    output logic                       o_ok,
    output logic [ils_pkg::CNT_W-1:0]  o_live_count
);
    import ils_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_ZERO   = 2'd1;
    localparam logic [1:0] S_STREAM = 2'd2;
    localparam logic [1:0] S_REV    = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [ACT_W-1:0] r_act, n_act;
    t_word            r_val, n_val;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [AW-1:0]    r_addr, n_addr;
    logic [AW-1:0]    r_hi, n_hi;
    logic [AW-1:0]    r_pos, n_pos;
    logic [CW-1:0]    r_left, n_left;
    logic             r_pend, n_pend;
    logic [AW-1:0]    r_pidx, n_pidx;
    logic [CW-1:0]    r_j, n_j;
    t_word            r_rd, n_rd;
    logic             r_ok, n_ok;
    logic             r_done, n_done;
    logic [1:0]       r_ph, n_ph;
    t_word            r_tmp, n_tmp;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_word         ram_wdata, ram_rdata;

    logic [XW-1:0] pos_x, cnt_x, dep_x;

    ils_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign pos_x = XW'(i_position);
    assign cnt_x = XW'(r_cnt);
    assign dep_x = XW'(DEPTH);

    always_comb begin
        n_state   = r_state;
        n_act     = r_act;
        n_val     = r_val;
        n_cnt     = r_cnt;
        n_addr    = r_addr;
        n_hi      = r_hi;
        n_pos     = r_pos;
        n_left    = r_left;
        n_pend    = 1'b0;
        n_pidx    = r_pidx;
        n_j       = r_j;
        n_rd      = r_rd;
        n_ok      = r_ok;
        n_done    = 1'b0;
        n_ph      = r_ph;
        n_tmp     = r_tmp;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = r_val;
        ram_raddr = r_addr;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_act  = i_action;
                    n_val  = i_item_value;
                    n_ok   = 1'b0;
                    n_rd   = '0;
                    n_done = 1'b1;
                    unique case (i_action)
                        ACT_SET: begin
                            if (pos_x < dep_x) begin
                                if (pos_x > cnt_x) begin
                                    n_addr  = AW'(r_cnt);
                                    n_pos   = AW'(i_position);
                                    n_done  = 1'b0;
                                    n_state = S_ZERO;
                                end else begin
                                    ram_we    = 1'b1;
                                    ram_waddr = AW'(i_position);
                                    ram_wdata = i_item_value;
                                    n_ok      = 1'b1;
                                    if (pos_x == cnt_x) begin
                                        n_cnt = r_cnt + 1'b1;
                                    end
                                end
                            end
                        end
                        ACT_REMOVE: begin
                            if (pos_x < cnt_x) begin
                                n_addr  = AW'(pos_x + 1'b1);
                                n_left  = CW'(cnt_x - pos_x - 1'b1);
                                n_ok    = 1'b1;
                                n_done  = 1'b0;
                                n_state = S_STREAM;
                            end
                        end
                        ACT_RETRIEVE: begin
                            if (pos_x == '0 || pos_x > cnt_x) begin
                                n_rd = -32'sd1;
                            end else begin
                                n_addr  = AW'(pos_x - 1'b1);
                                n_left  = CW'(1);
                                n_ok    = 1'b1;
                                n_done  = 1'b0;
                                n_state = S_STREAM;
                            end
                        end
                        ACT_LOCATE: begin
                            n_addr  = '0;
                            n_left  = r_cnt;
                            n_rd    = 32'(r_cnt) + 32'd1;
                            n_done  = 1'b0;
                            n_state = S_STREAM;
                        end
                        ACT_PUSH_F: begin
                            if (cnt_x < dep_x) begin
                                n_addr  = AW'(r_cnt - 1'b1);
                                n_left  = r_cnt;
                                n_ok    = 1'b1;
                                n_done  = 1'b0;
                                n_state = S_STREAM;
                            end
                        end
                        ACT_PUSH_B: begin
                            if (cnt_x < dep_x) begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(r_cnt);
                                ram_wdata = i_item_value;
                                n_cnt     = r_cnt + 1'b1;
                                n_ok      = 1'b1;
                            end
                        end
                        ACT_POP_F: begin
                            if (r_cnt != '0) begin
                                n_addr  = AW'(1);
                                n_left  = r_cnt - 1'b1;
                                n_ok    = 1'b1;
                                n_done  = 1'b0;
                                n_state = S_STREAM;
                            end
                        end
                        ACT_POP_B: begin
                            if (r_cnt != '0) begin
                                n_cnt = r_cnt - 1'b1;
                                n_ok  = 1'b1;
                            end
                        end
                        ACT_REM_ALL: begin
                            n_addr  = '0;
                            n_left  = r_cnt;
                            n_j     = '0;
                            n_ok    = 1'b1;
                            n_done  = 1'b0;
                            n_state = S_STREAM;
                        end
                        ACT_REVERSE: begin
                            n_ok = 1'b1;
                            if (r_cnt > CW'(1)) begin
                                n_addr  = '0;
                                n_hi    = AW'(r_cnt - 1'b1);
                                n_ph    = 2'd0;
                                n_done  = 1'b0;
                                n_state = S_REV;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ZERO: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                n_addr    = r_addr + 1'b1;
                if (r_addr == r_pos) begin
                    ram_wdata = r_val;
                    n_cnt     = CW'(r_pos) + 1'b1;
                    n_ok      = 1'b1;
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    ram_wdata = '0;
                end
            end
            S_STREAM: begin
                ram_raddr = r_addr;
                if (r_left != '0) begin
                    n_pend = 1'b1;
                    n_pidx = r_addr;
                    n_left = r_left - 1'b1;
                    n_addr = (r_act == ACT_PUSH_F) ? r_addr - 1'b1 : r_addr + 1'b1;
                end
                if (r_pend) begin
                    case (r_act) inside
                        ACT_REMOVE, ACT_POP_F: begin
                            ram_we    = 1'b1;
                            ram_waddr = r_pidx - 1'b1;
                            ram_wdata = ram_rdata;
                        end
                        ACT_PUSH_F: begin
                            ram_we    = 1'b1;
                            ram_waddr = r_pidx + 1'b1;
                            ram_wdata = ram_rdata;
                        end
                        ACT_REM_ALL: begin
                            if (ram_rdata != r_val) begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(r_j);
                                ram_wdata = ram_rdata;
                                n_j       = r_j + 1'b1;
                            end
                        end
                        ACT_LOCATE: begin
                            if (ram_rdata == r_val && !r_ok) begin
                                n_ok = 1'b1;
                                n_rd = 32'(r_pidx) + 32'd1;
                            end
                        end
                        ACT_RETRIEVE: begin
                            n_rd = ram_rdata;
                        end
                        default: begin
                        end
                    endcase
                end
                if (r_left == '0 && !r_pend) begin
                    case (r_act) inside
                        ACT_REMOVE, ACT_POP_F: begin
                            n_cnt = r_cnt - 1'b1;
                        end
                        ACT_PUSH_F: begin
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = r_val;
                            n_cnt     = r_cnt + 1'b1;
                        end
                        ACT_REM_ALL: begin
                            n_cnt = r_j;
                        end
                        default: begin
                        end
                    endcase
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_REV: begin
                n_ph = r_ph + 1'b1;
                case (r_ph)
                    2'd0: begin
                        ram_raddr = r_addr;
                    end
                    2'd1: begin
                        ram_raddr = r_hi;
                        n_tmp     = ram_rdata;
                    end
                    2'd2: begin
                        ram_we    = 1'b1;
                        ram_waddr = r_addr;
                        ram_wdata = ram_rdata;
                    end
                    default: begin
                        ram_we    = 1'b1;
                        ram_waddr = r_hi;
                        ram_wdata = r_tmp;
                        n_addr    = r_addr + 1'b1;
                        n_hi      = r_hi - 1'b1;
                        if (({1'b0, r_addr} + (AW+1)'(2)) >= {1'b0, r_hi}) begin
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_left  <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_left  <= n_left;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act  <= n_act;
        r_val  <= n_val;
        r_addr <= n_addr;
        r_hi   <= n_hi;
        r_pos  <= n_pos;
        r_pidx <= n_pidx;
        r_j    <= n_j;
        r_rd   <= n_rd;
        r_ok   <= n_ok;
        r_ph   <= n_ph;
        r_tmp  <= n_tmp;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_read_value = r_rd;
    assign o_ok         = r_ok;
    assign o_live_count = CNT_W'(r_cnt);

endmodule

FILE: hw/rtl/ils_chk.sv
// ----------------------------------------------------------------------------
// ils_chk
// Port-level checks of the indexed list store, bound to the top level.
// ----------------------------------------------------------------------------
module ils_chk #(
    parameter int DEPTH = 64
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [ils_pkg::ACT_W-1:0]  i_action,
    input logic [ils_pkg::POS_W-1:0]  i_position,
    input logic signed [31:0]         i_item_value,
    input logic                       o_done,
    input logic signed [31:0]         o_read_value,
    input logic                       o_ok,
    input logic [ils_pkg::CNT_W-1:0]  o_live_count
);
    import ils_pkg::*;

    a_accept_reacts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("transfer without work or result");

    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (32'(o_live_count) <= 32'(DEPTH)))
        else $error("live count above capacity");

    a_retrieve_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == ACT_RETRIEVE && i_position == '0)
        |=> (o_done && !o_ok && o_read_value == -32'sd1))
        else $error("retrieve at position zero not flagged");

endmodule

bind indexed_list_store ils_chk #(.DEPTH(DEPTH)) u_ils_chk (.*);
